/* hw/rtl/rdd_pkg.sv */
// Shared types and constants for the resource deadlock detector.
// Used by rdd_ctrl, rdd_datapath and resource_deadlock_detector_core; depends on nothing.
package rdd_pkg;

	// Default sizes of the stores; the top level hands them down as parameters.
	localparam int DEF_MAX_PROCS  = 16;
	localparam int DEF_MAX_RES    = 8;
	localparam int DEF_VALUE_BITS = 16;

	// Fixed widths of the item fields.
	localparam int OP_W       = 2;
	localparam int PROC_IDX_W = 4;
	localparam int RES_IDX_W  = 3;
	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 5;
	localparam int MASK_W     = 16;

	// Configuration registers.
	localparam int PCNT_W     = 5;
	localparam int RCNT_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(16);
	localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROC_COUNT = 1'b0,
		CFG_RES_COUNT  = 1'b1
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_WR_MAX   = 2'd0,
		OP_WR_ALLOC = 2'd1,
		OP_WR_TOTAL = 2'd2,
		OP_EVAL     = 2'd3
	} op_t;

	// Work launched into the read stage of the datapath.
	typedef enum logic [1:0] {
		ISS_NONE = 2'd0,
		ISS_SUM  = 2'd1,
		ISS_CMP  = 2'd2,
		ISS_ADD  = 2'd3
	} issue_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_PASS,
		S_PROC,
		S_CHECK,
		S_DECIDE,
		S_ADD,
		S_ADVANCE,
		S_REPORT
	} ctrl_state_t;

	typedef struct packed {
		logic   load;
		logic   eval_init;
		issue_t issue;
		logic   pi_clr;
		logic   pi_inc;
		logic   rj_clr;
		logic   rj_inc;
		logic   clr_progress;
		logic   clr_fail;
		logic   mark;
		logic   report;
	} dp_cmd_t;

	typedef struct packed {
		logic rj_last;
		logic pi_last;
		logic proc_done;
		logic fits;
		logic all_done;
		logic progress;
	} dp_status_t;

endpackage

/* hw/rtl/rdd_ctrl.sv */
// Sequencer of the resource deadlock detector: walks the sum, check and add phases.
// Depends on rdd_pkg; drives rdd_datapath through dp_cmd_t and reads dp_status_t.
module rdd_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rdd_pkg::OP_W-1:0] op,
	input  rdd_pkg::dp_status_t      st,
	output rdd_pkg::dp_cmd_t         cmd,
	output logic                     busy
);

	rdd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != rdd_pkg::S_IDLE);
		unique case (state_q)
			rdd_pkg::S_IDLE: begin
				if (start) begin
					if (op == rdd_pkg::OP_EVAL) begin
						cmd.eval_init = 1'b1;
						state_d       = rdd_pkg::S_SUM;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			rdd_pkg::S_SUM: begin
				cmd.issue  = rdd_pkg::ISS_SUM;
				cmd.rj_inc = 1'b1;
				if (st.rj_last) begin
					cmd.pi_inc = 1'b1;
					if (st.pi_last) begin
						state_d = rdd_pkg::S_PASS;
					end
				end
			end
			rdd_pkg::S_PASS: begin
				cmd.pi_clr       = 1'b1;
				cmd.clr_progress = 1'b1;
				state_d          = rdd_pkg::S_PROC;
			end
			rdd_pkg::S_PROC: begin
				if (st.proc_done) begin
					state_d = rdd_pkg::S_ADVANCE;
				end else begin
					cmd.rj_clr   = 1'b1;
					cmd.clr_fail = 1'b1;
					state_d      = rdd_pkg::S_CHECK;
				end
			end
			rdd_pkg::S_CHECK: begin
				cmd.issue  = rdd_pkg::ISS_CMP;
				cmd.rj_inc = 1'b1;
				if (st.rj_last) begin
					state_d = rdd_pkg::S_DECIDE;
				end
			end
			rdd_pkg::S_DECIDE: begin
				// The last compare of the row resolves in this cycle.
				if (st.fits) begin
					cmd.mark = 1'b1;
					state_d  = rdd_pkg::S_ADD;
				end else begin
					state_d = rdd_pkg::S_ADVANCE;
				end
			end
			rdd_pkg::S_ADD: begin
				cmd.issue  = rdd_pkg::ISS_ADD;
				cmd.rj_inc = 1'b1;
				if (st.rj_last) begin
					state_d = rdd_pkg::S_ADVANCE;
				end
			end
			rdd_pkg::S_ADVANCE: begin
				if (st.all_done || (st.pi_last && !st.progress)) begin
					state_d = rdd_pkg::S_REPORT;
				end else if (st.pi_last) begin
					state_d = rdd_pkg::S_PASS;
				end else begin
					cmd.pi_inc = 1'b1;
					state_d    = rdd_pkg::S_PROC;
				end
			end
			rdd_pkg::S_REPORT: begin
				cmd.report = 1'b1;
				state_d    = rdd_pkg::S_IDLE;
			end
			default: begin
				state_d = rdd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/rdd_datapath.sv */
// Datapath of the resource deadlock detector: claim, allocation and total stores,
// available vector, finished flags and the result register. Depends on rdd_pkg.
module rdd_datapath #(
	parameter int MAX_PROCS  = rdd_pkg::DEF_MAX_PROCS,
	parameter int MAX_RES    = rdd_pkg::DEF_MAX_RES,
	parameter int VALUE_BITS = rdd_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rdd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [rdd_pkg::OP_W-1:0]         op,
	input  logic [rdd_pkg::PROC_IDX_W-1:0]   proc_index,
	input  logic [rdd_pkg::RES_IDX_W-1:0]    res_index,
	input  logic [rdd_pkg::VALUE_W-1:0]      value,
	input  rdd_pkg::dp_cmd_t                 cmd,
	output rdd_pkg::dp_status_t              st,
	output logic                             done,
	output logic                             deadlock,
	output logic [rdd_pkg::COUNT_W-1:0]      finished_count,
	output logic [rdd_pkg::MASK_W-1:0]       finished_mask
);

	localparam int PI_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RJ_W    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int DEPTH   = MAX_PROCS * MAX_RES;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TALLY_W = $clog2(MAX_PROCS + 1);
	localparam int NRC_W   = $clog2(MAX_RES + 1);
	// Available can sink to minus the sum of every allocation in a column.
	localparam int AVAIL_W = VALUE_BITS + $clog2(MAX_PROCS + 1) + 1;

	logic [rdd_pkg::PCNT_W-1:0] proc_cnt_q;
	logic [rdd_pkg::RCNT_W-1:0] res_cnt_q;
	logic [TALLY_W-1:0]         np_c;
	logic [NRC_W-1:0]           nr_c;

	logic [PI_W-1:0]       pi_q;
	logic [RJ_W-1:0]       rj_q;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic [VALUE_BITS-1:0] wr_val;
	logic                  wr_row_ok;
	logic                  wr_col_ok;

	logic [VALUE_BITS-1:0] max_mem   [DEPTH];
	logic [VALUE_BITS-1:0] alloc_mem [DEPTH];
	logic [VALUE_BITS-1:0] total_mem [MAX_RES];

	logic [VALUE_BITS-1:0] max_rd_s1;
	logic [VALUE_BITS-1:0] alloc_rd_s1;
	logic [VALUE_BITS-1:0] total_rd_s1;
	logic [RJ_W-1:0]       j_s1;
	logic                  first_s1;
	rdd_pkg::issue_t       issue_s1;

	logic signed [AVAIL_W-1:0] avail_q [MAX_RES];
	logic signed [AVAIL_W-1:0] avail_cur;
	logic signed [AVAIL_W-1:0] alloc_ext;
	logic signed [AVAIL_W-1:0] max_ext;
	logic signed [AVAIL_W-1:0] total_ext;
	logic signed [AVAIL_W-1:0] need_ext;
	logic                      cmp_fail_c;

	logic [MAX_PROCS-1:0]                       flags_q;
	logic [MAX_PROCS+rdd_pkg::MASK_W-1:0]       flags_ext;
	logic [TALLY_W-1:0]                         tally_q;
	logic                                       progress_q;
	logic                                       fail_q;
	logic                                       done_q;

	// Register values outside their legal range are pulled into 1..max.
	always_comb begin
		if (proc_cnt_q == '0) begin
			np_c = TALLY_W'(1);
		end else if (int'(proc_cnt_q) > MAX_PROCS) begin
			np_c = TALLY_W'(MAX_PROCS);
		end else begin
			np_c = TALLY_W'(proc_cnt_q);
		end
		if (res_cnt_q == '0) begin
			nr_c = NRC_W'(1);
		end else if (int'(res_cnt_q) > MAX_RES) begin
			nr_c = NRC_W'(MAX_RES);
		end else begin
			nr_c = NRC_W'(res_cnt_q);
		end
	end

	assign rd_addr   = ADDR_W'(int'(pi_q) * MAX_RES + int'(rj_q));
	assign wr_addr   = ADDR_W'(int'(proc_index) * MAX_RES + int'(res_index));
	assign wr_val    = VALUE_BITS'(value);
	assign wr_row_ok = (int'(proc_index) < MAX_PROCS);
	assign wr_col_ok = (int'(res_index) < MAX_RES);

	// Store writes from load items.
	always_ff @(posedge clk) begin
		if (cmd.load && wr_col_ok) begin
			unique case (rdd_pkg::op_t'(op))
				rdd_pkg::OP_WR_MAX: begin
					if (wr_row_ok) begin
						max_mem[wr_addr] <= wr_val;
					end
				end
				rdd_pkg::OP_WR_ALLOC: begin
					if (wr_row_ok) begin
						alloc_mem[wr_addr] <= wr_val;
					end
				end
				rdd_pkg::OP_WR_TOTAL: begin
					total_mem[RJ_W'(res_index)] <= wr_val;
				end
				default: begin
				end
			endcase
		end
	end

	// Registered reads, one element of the walk per cycle while the sequencer issues work.
	always_ff @(posedge clk) begin
		max_rd_s1   <= max_mem[rd_addr];
		alloc_rd_s1 <= alloc_mem[rd_addr];
		total_rd_s1 <= total_mem[rj_q];
		j_s1        <= rj_q;
		first_s1    <= (pi_q == '0);
	end

	assign avail_cur  = avail_q[j_s1];
	assign alloc_ext  = $signed({{(AVAIL_W - VALUE_BITS){1'b0}}, alloc_rd_s1});
	assign max_ext    = $signed({{(AVAIL_W - VALUE_BITS){1'b0}}, max_rd_s1});
	assign total_ext  = $signed({{(AVAIL_W - VALUE_BITS){1'b0}}, total_rd_s1});
	assign need_ext   = max_ext - alloc_ext;
	assign cmp_fail_c = (issue_s1 == rdd_pkg::ISS_CMP) && (need_ext > avail_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_cnt_q <= rdd_pkg::PCNT_RESET;
			res_cnt_q  <= rdd_pkg::RCNT_RESET;
			pi_q       <= '0;
			rj_q       <= '0;
			issue_s1   <= rdd_pkg::ISS_NONE;
			flags_q    <= '0;
			tally_q    <= '0;
			progress_q <= 1'b0;
			fail_q     <= 1'b0;
			done_q     <= 1'b0;
			for (int k = 0; k < MAX_RES; k++) begin
				avail_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (rdd_pkg::cfg_idx_t'(cfg_index))
					rdd_pkg::CFG_PROC_COUNT: proc_cnt_q <= rdd_pkg::PCNT_W'(cfg_data);
					rdd_pkg::CFG_RES_COUNT:  res_cnt_q  <= rdd_pkg::RCNT_W'(cfg_data);
					default: begin
					end
				endcase
			end

			if (cmd.eval_init || cmd.pi_clr) begin
				pi_q <= '0;
			end else if (cmd.pi_inc) begin
				pi_q <= st.pi_last ? '0 : pi_q + PI_W'(1);
			end

			if (cmd.eval_init || cmd.rj_clr) begin
				rj_q <= '0;
			end else if (cmd.rj_inc) begin
				rj_q <= st.rj_last ? '0 : rj_q + RJ_W'(1);
			end

			issue_s1 <= cmd.issue;

			case (issue_s1)
				rdd_pkg::ISS_SUM: begin
					avail_q[j_s1] <= (first_s1 ? total_ext : avail_cur) - alloc_ext;
				end
				rdd_pkg::ISS_ADD: begin
					avail_q[j_s1] <= avail_cur + alloc_ext;
				end
				default: begin
				end
			endcase

			if (cmd.clr_fail) begin
				fail_q <= 1'b0;
			end else if (cmp_fail_c) begin
				fail_q <= 1'b1;
			end

			if (cmd.eval_init) begin
				flags_q <= '0;
				tally_q <= '0;
			end else if (cmd.mark) begin
				flags_q[pi_q] <= 1'b1;
				tally_q       <= tally_q + TALLY_W'(1);
			end

			if (cmd.clr_progress) begin
				progress_q <= 1'b0;
			end else if (cmd.mark) begin
				progress_q <= 1'b1;
			end

			done_q <= cmd.report;
		end
	end

	assign flags_ext = (MAX_PROCS + rdd_pkg::MASK_W)'(flags_q);

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			deadlock       <= (tally_q != np_c);
			finished_count <= rdd_pkg::COUNT_W'(tally_q);
			finished_mask  <= flags_ext[rdd_pkg::MASK_W-1:0];
		end
	end

	assign done         = done_q;
	assign st.rj_last   = (int'(rj_q) == int'(nr_c) - 1);
	assign st.pi_last   = (int'(pi_q) == int'(np_c) - 1);
	assign st.proc_done = flags_q[pi_q];
	assign st.fits      = !(fail_q || cmp_fail_c);
	assign st.all_done  = (tally_q == np_c);
	assign st.progress  = progress_q;

	// The finished count always agrees with the finished flags.
	a_tally_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q == TALLY_W'($countones(flags_q)))
		else $error("finished tally disagrees with finished flags");

	// A process is only ever marked finished once per evaluation.
	a_mark_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> !flags_q[pi_q])
		else $error("process marked finished twice");

	// The result strobe follows a report command and nothing else.
	a_done_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.report))
		else $error("result strobe without report");

	// The walk never addresses a column beyond the resource count in use.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue != rdd_pkg::ISS_NONE) |-> (int'(rj_q) < int'(nr_c)))
		else $error("column counter out of range");

endmodule

/* hw/rtl/resource_deadlock_detector_core.sv */
// Top level of the resource deadlock detector (banker's safety check).
// Depends on rdd_pkg, rdd_ctrl and rdd_datapath.
// Usage. An item is taken at a rising edge with start high and busy low. The
// write max claim and write allocation ops store one 16-bit entry at
// (proc_index, res_index) and write total one at res_index; busy stays low and
// no result comes. Writes whose indexes exceed the store sizes are dropped.
// Evaluate raises busy and first forms available = total - column sums of
// allocation, then passes over the processes in index order: a finished process
// is skipped, an unfinished one has its need compared with available, and when
// it fits its allocation goes back into available. Passes repeat until all are
// finished or a pass makes no progress. A report state follows and done is high
// in the next cycle, exactly one cycle, with deadlock, finished_count and
// finished_mask valid. The walk reads one store element at a time through the
// single read port of the claim and allocation stores. The receiver cannot
// stall; busy falls in the done cycle, so a new item may start while the result
// is shown. Reset clears the sequencer, the available vector and the finished
// flags and sets the counts to 16 and 8; the stores hold nothing defined until
// written. Configuration writes (cfg_we) act at once and are meant for idle.
module resource_deadlock_detector_core #(
	parameter int MAX_PROCS  = rdd_pkg::DEF_MAX_PROCS,
	parameter int MAX_RES    = rdd_pkg::DEF_MAX_RES,
	parameter int VALUE_BITS = rdd_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rdd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic [rdd_pkg::OP_W-1:0]         op,
	input  logic [rdd_pkg::PROC_IDX_W-1:0]   proc_index,
	input  logic [rdd_pkg::RES_IDX_W-1:0]    res_index,
	input  logic [rdd_pkg::VALUE_W-1:0]      value,
	output logic                             done,
	output logic                             deadlock,
	output logic [rdd_pkg::COUNT_W-1:0]      finished_count,
	output logic [rdd_pkg::MASK_W-1:0]       finished_mask
);

	// Commands flow from the sequencer to the datapath, status flows back.
	rdd_pkg::dp_cmd_t    cmd;
	rdd_pkg::dp_status_t st;

	// The sequencer owns the handshake: it decides whether an item is a
	// store write or the start of an evaluation.
	rdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the stores, the configuration registers and the
	// result register that drives the output strobe.
	rdd_datapath #(
		.MAX_PROCS  (MAX_PROCS),
		.MAX_RES    (MAX_RES),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.proc_index     (proc_index),
		.res_index      (res_index),
		.value          (value),
		.cmd            (cmd),
		.st             (st),
		.done           (done),
		.deadlock       (deadlock),
		.finished_count (finished_count),
		.finished_mask  (finished_mask)
	);

endmodule

/* bench/tb_top.sv */
// Self-checking bench for resource_deadlock_detector_core: random banker's states, checked verdicts.
// Depends on rdd_pkg and the detector RTL only; it keeps its own safety-check predictor.
module tb_top;
	import rdd_pkg::*;

	localparam int PROCS = DEF_MAX_PROCS;
	localparam int RES   = DEF_MAX_RES;

	// One item as the driver presents it.
	typedef struct {
		op_t                   kind;
		logic [PROC_IDX_W-1:0] row;
		logic [RES_IDX_W-1:0]  col;
		logic [VALUE_W-1:0]    units;
	} detector_item_t;

	// One verdict of the safety check, as the block reports it.
	typedef struct packed {
		logic               deadlock;
		logic [COUNT_W-1:0] count;
		logic [MASK_W-1:0]  mask;
	} safety_verdict_t;

	// All block inputs start from known values; reset is held from time zero.
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  start      = 1'b0;
	logic [OP_W-1:0]       op         = '0;
	logic [PROC_IDX_W-1:0] proc_index = '0;
	logic [RES_IDX_W-1:0]  res_index  = '0;
	logic [VALUE_W-1:0]    value      = '0;
	logic                  busy;
	logic                  done;
	logic                  deadlock;
	logic [COUNT_W-1:0]    finished_count;
	logic [MASK_W-1:0]     finished_mask;

	resource_deadlock_detector_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.proc_index     (proc_index),
		.res_index      (res_index),
		.value          (value),
		.done           (done),
		.deadlock       (deadlock),
		.finished_count (finished_count),
		.finished_mask  (finished_mask)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The run is bounded far above its slowest legal length: even if every item were
	// a full-size evaluate at its worst cost, it would still end well inside this.
	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	// Shadow copy of the detector state, kept in step with accepted items.
	logic [VALUE_W-1:0] claim_mem [PROCS][RES];
	logic [VALUE_W-1:0] alloc_mem [PROCS][RES];
	logic [VALUE_W-1:0] total_mem [RES];
	logic [PCNT_W-1:0]  proc_cnt_reg = PCNT_RESET;
	logic [RCNT_W-1:0]  res_cnt_reg  = RCNT_RESET;

	detector_item_t  pending_items [$];
	safety_verdict_t verdicts_due  [$];

	int  items_queued   = 0;
	int  items_taken    = 0;
	int  verdicts_seen  = 0;
	int  deadlocks_seen = 0;
	int  settings_used  = 1;
	int  fail_count     = 0;
	int  gap_left       = 0;
	bit  quiet_tail     = 1'b0;

	// A count register of zero behaves as one, and anything above the store size
	// behaves as the store size.
	function automatic int saturate_count(int raw, int hi);
		if (raw < 1)
			return 1;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// Banker's safety check on the shadow state. Available starts as total minus the
	// column sums of allocation and may go negative; need is claim minus allocation,
	// also signed. Passes run in index order until everyone is done or a pass stalls.
	function automatic safety_verdict_t check_safety();
		int              np;
		int              nr;
		int              i;
		int              j;
		int              tally;
		longint          avail [RES];
		longint          need;
		logic [MASK_W-1:0] done_mask;
		bit              progress;
		bit              fits;
		safety_verdict_t v;
		np = saturate_count(proc_cnt_reg, PROCS);
		nr = saturate_count(res_cnt_reg, RES);
		for (j = 0; j < nr; j++) begin
			avail[j] = longint'(total_mem[j]);
			for (i = 0; i < np; i++)
				avail[j] -= longint'(alloc_mem[i][j]);
		end
		done_mask = '0;
		tally = 0;
		progress = 1'b1;
		while (tally < np && progress) begin
			progress = 1'b0;
			for (i = 0; i < np; i++) begin
				if (!done_mask[i]) begin
					fits = 1'b1;
					for (j = 0; j < nr; j++) begin
						need = longint'(claim_mem[i][j]) - longint'(alloc_mem[i][j]);
						if (need > avail[j])
							fits = 1'b0;
					end
					if (fits) begin
						for (j = 0; j < nr; j++)
							avail[j] += longint'(alloc_mem[i][j]);
						done_mask[i] = 1'b1;
						tally++;
						progress = 1'b1;
					end
				end
			end
		end
		v.deadlock = (tally < np);
		v.count    = COUNT_W'(tally);
		v.mask     = done_mask;
		return v;
	endfunction

	// Applies one accepted item to the shadow state; an evaluate queues its verdict.
	function automatic void absorb_item(op_t kind, logic [PROC_IDX_W-1:0] row,
			logic [RES_IDX_W-1:0] col, logic [VALUE_W-1:0] units);
		case (kind)
			OP_WR_MAX:   claim_mem[row][col] = units;
			OP_WR_ALLOC: alloc_mem[row][col] = units;
			OP_WR_TOTAL: total_mem[col] = units;
			OP_EVAL:     verdicts_due.push_back(check_safety());
			default: ;
		endcase
	endfunction

	// Driver. An item is taken at an edge where start is high and busy is low. While the
	// block is busy the presented item is held; otherwise the next one is taken from the
	// pending queue, or, at random, an idle gap is inserted.
	always @(posedge clk) begin : item_driver
		detector_item_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!(start && busy)) begin
			if (start) begin
				absorb_item(op_t'(op), proc_index, res_index, value);
				items_taken++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 17);
				start <= 1'b0;
			end else begin
				nxt = pending_items.pop_front();
				op <= nxt.kind;
				proc_index <= nxt.row;
				res_index <= nxt.col;
				value <= nxt.units;
				start <= 1'b1;
			end
		end
	end

	// Monitor. A verdict is valid for exactly the cycle that done is high and is taken at
	// the edge that ends it; it is compared field by field with the oldest prediction.
	always @(posedge clk) begin : verdict_monitor
		safety_verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (verdicts_due.size() == 0) begin
				$error("result with no evaluate outstanding");
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				verdicts_seen++;
				deadlocks_seen += want.deadlock;
				if (deadlock !== want.deadlock) begin
					$error("deadlock: expected %0d, got %0d", want.deadlock, deadlock);
					fail_count++;
				end
				if (finished_count !== want.count) begin
					$error("finished_count: expected %0d, got %0d", want.count,
						finished_count);
					fail_count++;
				end
				if (finished_mask !== want.mask) begin
					$error("finished_mask: expected %h, got %h", want.mask, finished_mask);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_item(op_t kind, int row, int col, logic [VALUE_W-1:0] units);
		detector_item_t it;
		it.kind  = kind;
		it.row   = PROC_IDX_W'(row);
		it.col   = RES_IDX_W'(col);
		it.units = units;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// The index and value fields of an evaluate are don't-care, so they carry noise.
	task automatic queue_eval();
		queue_item(OP_EVAL, $urandom_range(0, 15), $urandom_range(0, 7),
			VALUE_W'($urandom_range(0, 65535)));
	endtask

	// Writes a complete banker's state for the rows and columns in use. Claims sit a
	// little above allocations, and the slack left in each total decides how easily the
	// processes drain. Now and then a full-range value drives a column far out of reach
	// or makes available negative.
	task automatic queue_scenario(int np, int nr);
		int                 colsum [RES];
		int                 i;
		int                 j;
		int                 style;
		int                 t;
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] m;
		style = $urandom_range(0, 3);
		for (j = 0; j < RES; j++)
			colsum[j] = 0;
		for (i = 0; i < np; i++) begin
			for (j = 0; j < nr; j++) begin
				if ($urandom_range(0, 31) == 0)
					a = VALUE_W'($urandom_range(0, 65535));
				else
					a = VALUE_W'($urandom_range(0, 6));
				if ($urandom_range(0, 15) == 0)
					m = VALUE_W'($urandom_range(0, 65535));
				else
					m = a + VALUE_W'($urandom_range(0, 6));
				queue_item(OP_WR_ALLOC, i, j, a);
				queue_item(OP_WR_MAX, i, j, m);
				colsum[j] += a;
			end
		end
		for (j = 0; j < nr; j++) begin
			case (style)
				0: t = colsum[j] + $urandom_range(0, 2);
				1: t = colsum[j] + $urandom_range(0, 8);
				2: t = colsum[j] + $urandom_range(3, 12);
				default: t = colsum[j] - $urandom_range(0, 3);
			endcase
			if (t < 0)
				t = 0;
			queue_item(OP_WR_TOTAL, $urandom_range(0, 15), j, VALUE_W'(t));
		end
	endtask

	// A single random write, mostly inside the area in use and sometimes anywhere.
	task automatic queue_tweak(int np, int nr);
		int                 row;
		int                 col;
		logic [VALUE_W-1:0] units;
		if ($urandom_range(0, 4) == 0) begin
			row = $urandom_range(0, 15);
			col = $urandom_range(0, 7);
		end else begin
			row = $urandom_range(0, np - 1);
			col = $urandom_range(0, nr - 1);
		end
		if ($urandom_range(0, 9) == 0)
			units = VALUE_W'($urandom_range(0, 65535));
		else
			units = VALUE_W'($urandom_range(0, 9));
		queue_item(op_t'($urandom_range(0, 2)), row, col, units);
	endtask

	// Waits until every item is taken and every verdict is in, then waits out the given
	// tail so that a trailing write has landed before the counts change.
	task automatic wait_idle(int tail);
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || busy !== 1'b0 ||
			verdicts_due.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_counts(logic [CFG_DATA_W-1:0] pc, logic [CFG_DATA_W-1:0] rc);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROC_COUNT;
		cfg_data <= pc;
		@(posedge clk);
		cfg_index <= CFG_RES_COUNT;
		cfg_data <= rc;
		@(posedge clk);
		cfg_we <= 1'b0;
		proc_cnt_reg = pc;
		res_cnt_reg = rc[RCNT_W-1:0];
		settings_used++;
	endtask

	initial begin : stimulus
		int pc;
		int rc;
		int np;
		int nr;
		int phase;
		// The opening settings cover a zero count (acting as one), the smallest and the
		// largest legal counts, and counts beyond the stores that must saturate.
		int fixed_pc [7] = '{0, 1, 31, 16, 17, 3, 0};
		int fixed_rc [7] = '{0, 1, 15, 8, 9, 0, 5};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Every store entry is written before the first evaluate, so no stale entry is
		// ever read. The first checks run at the counts left by reset.
		queue_scenario(PROCS, RES);
		queue_eval();
		queue_eval();

		// Directed items at full size: the top value in the last row and column, a huge
		// total, an allocation that sends available far negative and then its repair.
		queue_item(OP_WR_MAX, 15, 7, '1);
		queue_eval();
		queue_item(OP_WR_TOTAL, 0, 7, '1);
		queue_eval();
		queue_item(OP_WR_ALLOC, 0, 0, '1);
		queue_eval();
		queue_item(OP_WR_MAX, 0, 0, '1);
		queue_eval();
		queue_item(OP_WR_ALLOC, 0, 0, '0);
		queue_item(OP_WR_MAX, 0, 0, '0);
		queue_item(OP_WR_TOTAL, 0, 0, '0);
		queue_eval();
		wait_idle(4);

		// Random part. Most settings are small so that evaluates stay cheap; each one
		// gets a fresh well-formed state when it is small, then rounds of random writes
		// each followed by an evaluate. The tail runs with no random idle gaps.
		phase = 0;
		while (items_queued < 800) begin
			if (phase < 7) begin
				pc = fixed_pc[phase];
				rc = fixed_rc[phase];
			end else if ($urandom_range(0, 3) != 0) begin
				pc = $urandom_range(1, 6);
				rc = $urandom_range(1, 4);
			end else begin
				pc = $urandom_range(0, 31);
				rc = $urandom_range(0, 15);
			end
			if (items_queued >= 650)
				quiet_tail = 1'b1;
			write_counts(CFG_DATA_W'(pc), CFG_DATA_W'(rc));
			np = saturate_count(pc, PROCS);
			nr = saturate_count(rc % 16, RES);
			if (np * nr <= 32)
				queue_scenario(np, nr);
			queue_eval();
			repeat ($urandom_range(2, 5)) begin
				repeat ($urandom_range(1, 4)) queue_tweak(np, nr);
				queue_eval();
			end
			wait_idle(4);
			phase++;
		end

		wait_idle(20);
		$display("Checked %0d safety verdicts, %0d of them deadlocked, over %0d items",
			verdicts_seen, deadlocks_seen, items_taken);
		$display("and %0d process/resource count settings.", settings_used);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
